FILE: hdl/inds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inds_pkg
// Shared widths, pipeline tag type and register indexes of the diffuse shader.
// ----------------------------------------------------------------------------
package inds_pkg;

  localparam int CW    = 16;
  localparam int IW    = 16;
  localparam int PIXW  = 8;
  localparam int NRMW  = 3 * CW;
  localparam int NSH   = CW - 2;
  localparam int PW    = 2 * CW;
  localparam int SUMW  = PW + 2;
  localparam int NW    = SUMW - NSH;
  localparam int SW    = 2 * NW + 2;
  localparam int LNW   = CW + NW;
  localparam int DW    = LNW + 2;
  localparam int MW    = 62;
  localparam int RW    = MW / 2;
  localparam int REMW  = RW + 3;
  localparam int KMAX  = (MW - 2) / 2;
  localparam int PBW   = $clog2(MW);
  localparam int KW    = PBW - 1;
  localparam int EW    = KW + 1;
  localparam int NUMW  = DW - 1 + 2 * KMAX;
  localparam int INW   = 4 * PIXW + 3 * CW;
  localparam int OUTW  = 4 * PIXW;
  localparam int CIW   = 3;

  typedef struct packed {
    logic            valid;
    logic            unlit;
    logic [OUTW-1:0] rgba;
  } tag_t;

  typedef enum logic [CIW-1:0] {
    REG_LIGHT_X  = 3'd0,
    REG_LIGHT_Y  = 3'd1,
    REG_LIGHT_Z  = 3'd2,
    REG_NORMAL_A = 3'd3,
    REG_NORMAL_B = 3'd4,
    REG_NORMAL_C = 3'd5
  } cfg_reg_e;

endpackage

FILE: hdl/inds_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inds_normal
// Interpolates the vertex normal and forms both squared lengths and the
// negated dot product with the light in four register stages.
// ----------------------------------------------------------------------------
module inds_normal (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  inds_pkg::tag_t                    tag_i,
  input  logic signed [inds_pkg::CW-1:0]    w_i [3],
  input  logic [inds_pkg::NRMW-1:0]         nrm_i [3],
  input  logic signed [inds_pkg::CW-1:0]    lt_i [3],
  output inds_pkg::tag_t                    tag_o,
  output logic [inds_pkg::SW-1:0]           sl_o,
  output logic [inds_pkg::SW-1:0]           sn_o,
  output logic signed [inds_pkg::DW-1:0]    d_o
);

  logic signed [inds_pkg::CW-1:0]     comp [3][3];
  logic signed [inds_pkg::PW-1:0]     prod_q [3][3];
  logic signed [inds_pkg::SUMW-1:0]   sum [3];
  logic signed [inds_pkg::NW-1:0]     n_q [3];
  logic signed [2*inds_pkg::NW-1:0]   sqn_q [3];
  logic signed [inds_pkg::PW-1:0]     sql_q [3];
  logic signed [inds_pkg::LNW-1:0]    ln_q [3];
  logic [inds_pkg::SW-1:0]            sl_d;
  logic [inds_pkg::SW-1:0]            sn_d;
  logic signed [inds_pkg::DW-1:0]     dsum;
  logic signed [inds_pkg::DW-1:0]     d_d;
  inds_pkg::tag_t                     tag1_q, tag2_q, tag3_q, tag4_q;
  inds_pkg::tag_t                     tag4_d;
  logic [inds_pkg::SW-1:0]            sl_q, sn_q;
  logic signed [inds_pkg::DW-1:0]     d_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        comp[j][i] = $signed(nrm_i[j][i*inds_pkg::CW +: inds_pkg::CW]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      sum[i] = prod_q[0][i] + prod_q[1][i] + prod_q[2][i];
    end
    sl_d = inds_pkg::SW'({2'b00, sql_q[0]} + {2'b00, sql_q[1]} + {2'b00, sql_q[2]});
    sn_d = {2'b00, sqn_q[0]} + {2'b00, sqn_q[1]} + {2'b00, sqn_q[2]};
    dsum = ln_q[0] + ln_q[1] + ln_q[2];
    d_d  = -dsum;
    tag4_d       = tag3_q;
    tag4_d.unlit = (sl_d == '0) || (sn_d == '0) || (d_d <= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[j][i] <= w_i[j] * comp[j][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        n_q[i]   <= inds_pkg::NW'(sum[i] >>> inds_pkg::NSH);
        sqn_q[i] <= n_q[i] * n_q[i];
        sql_q[i] <= lt_i[i] * lt_i[i];
        ln_q[i]  <= lt_i[i] * n_q[i];
      end
      sl_q <= sl_d;
      sn_q <= sn_d;
      d_q  <= d_d;
    end
  end

  assign tag_o = tag4_q;
  assign sl_o  = sl_q;
  assign sn_o  = sn_q;
  assign d_o   = d_q;

endmodule

FILE: hdl/inds_rsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inds_rsqrt
// Normalizes both squared lengths by even shifts and takes their integer
// square roots, one root bit per register stage, for two lanes side by side.
// ----------------------------------------------------------------------------
module inds_rsqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  inds_pkg::tag_t                    tag_i,
  input  logic [inds_pkg::SW-1:0]           s_i [2],
  input  logic signed [inds_pkg::DW-1:0]    d_i,
  output inds_pkg::tag_t                    tag_o,
  output logic [inds_pkg::RW-1:0]           t_o [2],
  output logic [inds_pkg::KW-1:0]           k_o [2],
  output logic signed [inds_pkg::DW-1:0]    d_o
);

  localparam int NS = inds_pkg::RW + 1;

  logic [inds_pkg::PBW-1:0]         pa [2];
  logic [inds_pkg::PBW-1:0]         span [2];
  logic [inds_pkg::SW-1:0]          sa_q [2];
  logic [inds_pkg::KW-1:0]          ka_q [2];
  inds_pkg::tag_t                   taga_q;
  logic signed [inds_pkg::DW-1:0]   da_q;

  logic [inds_pkg::MW-1:0]          rad_q [NS][2];
  logic [inds_pkg::REMW-1:0]        rem_q [NS][2];
  logic [inds_pkg::RW-1:0]          root_q [NS][2];
  logic [inds_pkg::KW-1:0]          k_q [NS][2];
  inds_pkg::tag_t                   tag_q [NS];
  logic signed [inds_pkg::DW-1:0]   d_q [NS];

  logic [inds_pkg::REMW-1:0]        cand [inds_pkg::RW][2];
  logic [inds_pkg::REMW-1:0]        trial [inds_pkg::RW][2];
  logic [inds_pkg::REMW-1:0]        rem_d [inds_pkg::RW][2];
  logic [inds_pkg::RW-1:0]          root_d [inds_pkg::RW][2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pa[l] = '0;
      for (int b = 0; b < inds_pkg::SW; b++) begin
        if (s_i[l][b]) begin
          pa[l] = inds_pkg::PBW'(b);
        end
      end
      span[l] = inds_pkg::PBW'(inds_pkg::MW - 1) - pa[l];
    end
    for (int g = 0; g < inds_pkg::RW; g++) begin
      for (int l = 0; l < 2; l++) begin
        cand[g][l]  = {rem_q[g][l][inds_pkg::RW:0], rad_q[g][l][inds_pkg::MW-1 -: 2]};
        trial[g][l] = {1'b0, root_q[g][l], 2'b01};
        if (cand[g][l] >= trial[g][l]) begin
          rem_d[g][l]  = cand[g][l] - trial[g][l];
          root_d[g][l] = {root_q[g][l][inds_pkg::RW-2:0], 1'b1};
        end else begin
          rem_d[g][l]  = cand[g][l];
          root_d[g][l] = {root_q[g][l][inds_pkg::RW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taga_q <= '0;
      for (int g = 0; g < NS; g++) begin
        tag_q[g] <= '0;
      end
    end else if (en_i) begin
      taga_q   <= tag_i;
      tag_q[0] <= taga_q;
      for (int g = 0; g < inds_pkg::RW; g++) begin
        tag_q[g+1] <= tag_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      da_q   <= d_i;
      d_q[0] <= da_q;
      for (int l = 0; l < 2; l++) begin
        sa_q[l]      <= s_i[l];
        ka_q[l]      <= span[l][inds_pkg::PBW-1:1];
        rad_q[0][l]  <= inds_pkg::MW'(sa_q[l]) << {ka_q[l], 1'b0};
        rem_q[0][l]  <= '0;
        root_q[0][l] <= '0;
        k_q[0][l]    <= ka_q[l];
      end
      for (int g = 0; g < inds_pkg::RW; g++) begin
        d_q[g+1] <= d_q[g];
        for (int l = 0; l < 2; l++) begin
          rad_q[g+1][l]  <= rad_q[g][l] << 2;
          rem_q[g+1][l]  <= rem_d[g][l];
          root_q[g+1][l] <= root_d[g][l];
          k_q[g+1][l]    <= k_q[g][l];
        end
      end
    end
  end

  assign tag_o = tag_q[NS-1];
  assign d_o   = d_q[NS-1];
  assign t_o   = root_q[NS-1];
  assign k_o   = k_q[NS-1];

endmodule

FILE: hdl/inds_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inds_divide
// Forms the product of the two roots and divides the scaled dot product by
// it, one quotient bit per register stage, saturating at unit intensity.
// ----------------------------------------------------------------------------
module inds_divide (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  inds_pkg::tag_t                    tag_i,
  input  logic [inds_pkg::RW-1:0]           t_i [2],
  input  logic [inds_pkg::KW-1:0]           k_i [2],
  input  logic signed [inds_pkg::DW-1:0]    d_i,
  output inds_pkg::tag_t                    tag_o,
  output logic [inds_pkg::IW:0]             q_o
);

  localparam int NS = inds_pkg::IW + 1;

  logic [inds_pkg::MW-1:0]     den1_q;
  logic [inds_pkg::EW-1:0]     e1_q;
  logic [inds_pkg::DW-2:0]     d1_q;
  inds_pkg::tag_t              tag1_q, tag2_q;
  logic [inds_pkg::NUMW-1:0]   num2_q;
  logic [inds_pkg::MW-1:0]     den2_q;

  logic [inds_pkg::MW-1:0]     rem_q [NS];
  logic [inds_pkg::MW-1:0]     den_q [NS];
  logic [inds_pkg::IW-1:0]     qb_q [NS];
  logic                        sat_q [NS];
  inds_pkg::tag_t              tag_q [NS];

  logic [inds_pkg::MW:0]       r2 [inds_pkg::IW];
  logic [inds_pkg::MW:0]       diff [inds_pkg::IW];

  always_comb begin
    for (int g = 0; g < inds_pkg::IW; g++) begin
      r2[g]   = {rem_q[g], 1'b0};
      diff[g] = r2[g] - {1'b0, den_q[g]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      for (int g = 0; g < NS; g++) begin
        tag_q[g] <= '0;
      end
    end else if (en_i) begin
      tag1_q   <= tag_i;
      tag2_q   <= tag1_q;
      tag_q[0] <= tag2_q;
      for (int g = 0; g < inds_pkg::IW; g++) begin
        tag_q[g+1] <= tag_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den1_q   <= t_i[0] * t_i[1];
      e1_q     <= {1'b0, k_i[0]} + {1'b0, k_i[1]};
      d1_q     <= d_i[inds_pkg::DW-2:0];
      num2_q   <= inds_pkg::NUMW'(d1_q) << e1_q;
      den2_q   <= den1_q;
      sat_q[0] <= num2_q >= inds_pkg::NUMW'(den2_q);
      rem_q[0] <= num2_q[inds_pkg::MW-1:0];
      den_q[0] <= den2_q;
      qb_q[0]  <= '0;
      for (int g = 0; g < inds_pkg::IW; g++) begin
        den_q[g+1] <= den_q[g];
        sat_q[g+1] <= sat_q[g];
        if (r2[g] >= {1'b0, den_q[g]}) begin
          rem_q[g+1] <= diff[g][inds_pkg::MW-1:0];
          qb_q[g+1]  <= {qb_q[g][inds_pkg::IW-2:0], 1'b1};
        end else begin
          rem_q[g+1] <= r2[g][inds_pkg::MW-1:0];
          qb_q[g+1]  <= {qb_q[g][inds_pkg::IW-2:0], 1'b0};
        end
      end
    end
  end

  assign tag_o = tag_q[NS-1];
  assign q_o   = sat_q[NS-1] ? {1'b1, {inds_pkg::IW{1'b0}}} : {1'b0, qb_q[NS-1]};

endmodule

FILE: hdl/interpolated_normal_diffuse_shade_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolated_normal_diffuse_shade_core
// Per-pixel Lambert shading with barycentric interpolation of vertex normals.
// One pixel is accepted every cycle while the skid register is empty; the 31 root stages
// and 16 divide stages set the depth. A skid register catches one result across an output
// stall, and input is held until the skid register drains.
// Reset clears all valid bits and loads the registers with their defaults
// (light pointing along negative z, all vertex normals zero).
// ----------------------------------------------------------------------------
module interpolated_normal_diffuse_shade_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [inds_pkg::CIW-1:0]       cfg_index_i,
  input  logic [inds_pkg::NRMW-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // red_in, green_in, blue_in, alpha_in, weight_a, weight_b, weight_c
  input  logic [inds_pkg::INW-1:0]       s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // red_out, green_out, blue_out, alpha_out
  output logic [inds_pkg::OUTW-1:0]      m_axis_tdata_o
);

  logic signed [inds_pkg::CW-1:0]    lt_q [3];
  logic [inds_pkg::NRMW-1:0]         nrm_q [3];
  logic                              en;
  inds_pkg::tag_t                    tag_in;
  logic signed [inds_pkg::CW-1:0]    w [3];
  inds_pkg::tag_t                    tag_n, tag_r, tag_v;
  logic [inds_pkg::SW-1:0]           s_n [2];
  logic signed [inds_pkg::DW-1:0]    d_n, d_r;
  logic [inds_pkg::RW-1:0]           t_r [2];
  logic [inds_pkg::KW-1:0]           k_r [2];
  logic [inds_pkg::IW:0]             q_v;
  logic [inds_pkg::OUTW-1:0]         shade;
  logic [inds_pkg::PIXW+inds_pkg::IW:0] scaled [3];
  logic                              out_v_q, skid_v_q;
  logic [inds_pkg::OUTW-1:0]         out_q, skid_q;
  logic                              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q[0]  <= '0;
      lt_q[1]  <= '0;
      lt_q[2]  <= -16'sd16384;
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        inds_pkg::REG_LIGHT_X:  lt_q[0]  <= $signed(cfg_data_i[inds_pkg::CW-1:0]);
        inds_pkg::REG_LIGHT_Y:  lt_q[1]  <= $signed(cfg_data_i[inds_pkg::CW-1:0]);
        inds_pkg::REG_LIGHT_Z:  lt_q[2]  <= $signed(cfg_data_i[inds_pkg::CW-1:0]);
        inds_pkg::REG_NORMAL_A: nrm_q[0] <= cfg_data_i;
        inds_pkg::REG_NORMAL_B: nrm_q[1] <= cfg_data_i;
        inds_pkg::REG_NORMAL_C: nrm_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  always_comb begin
    tag_in.valid = s_axis_tvalid_i;
    tag_in.unlit = 1'b0;
    tag_in.rgba  = s_axis_tdata_i[inds_pkg::OUTW-1:0];
    for (int j = 0; j < 3; j++) begin
      w[j] = $signed(s_axis_tdata_i[inds_pkg::OUTW + j*inds_pkg::CW +: inds_pkg::CW]);
    end
  end

  inds_normal u_normal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_in),
    .w_i    (w),
    .nrm_i  (nrm_q),
    .lt_i   (lt_q),
    .tag_o  (tag_n),
    .sl_o   (s_n[0]),
    .sn_o   (s_n[1]),
    .d_o    (d_n)
  );

  inds_rsqrt u_rsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_n),
    .s_i    (s_n),
    .d_i    (d_n),
    .tag_o  (tag_r),
    .t_o    (t_r),
    .k_o    (k_r),
    .d_o    (d_r)
  );

  inds_divide u_divide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_r),
    .t_i    (t_r),
    .k_i    (k_r),
    .d_i    (d_r),
    .tag_o  (tag_v),
    .q_o    (q_v)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = tag_v.rgba[c*inds_pkg::PIXW +: inds_pkg::PIXW] * q_v;
      shade[c*inds_pkg::PIXW +: inds_pkg::PIXW] =
        scaled[c][inds_pkg::IW +: inds_pkg::PIXW];
    end
    shade[3*inds_pkg::PIXW +: inds_pkg::PIXW] = tag_v.rgba[3*inds_pkg::PIXW +: inds_pkg::PIXW];
    if (tag_v.unlit) begin
      shade = '0;
    end
  end

  assign pop = out_v_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (tag_v.valid) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (tag_v.valid) begin
      if (!out_v_q || pop) begin
        out_q <= shade;
      end else begin
        skid_q <= shade;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && m_axis_tready_i) |=> !skid_v_q)
    else $error("skid register did not drain after an output transaction");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready_i && !skid_v_q && tag_v.valid) |=> (skid_v_q && out_v_q))
    else $error("pipeline result lost while the output was stalled");

endmodule
